FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");
// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("%m: forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

FILE: rtl/modexp_pkg.sv
`timescale 1ns / 1ps

package modexp_pkg;

  localparam int DATA_W    = 32;  // base and result field width
  localparam int CFG_W     = 32;  // configuration data width
  localparam int CFG_IDX_W = 1;   // configuration register index width

  localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_MUL,
    ST_SQR,
    ST_FINISH
  } state_e;

endpackage

FILE: rtl/modular_exponentiation_unit.sv
`timescale 1ns / 1ps
// Modular exponentiation, right-to-left binary square-and-multiply.
// Channels: s_axis carries one base value per transaction, m_axis returns
// one result per base. cfg (valid/ready, index, data) writes the exponent
// (index 0) and the modulus (index 1); write it only while the unit is idle.
// A modulus whose low OPERAND_WIDTH bits are zero acts as 2^OPERAND_WIDTH.
// One base is worked on at a time. A bit-serial interleaved modular
// multiplier (one doubling and one conditional add, each with a trial
// subtract, per cycle) is shared by the base reduction, the multiply and
// the square steps. A zero exponent goes straight to the finish state.
// A new base is taken only when the unit is back in the idle state, after
// the result of the last base has been moved into the output register.
// Reset clears the state machine and output valid; the exponent returns to
// 0 and the modulus to 1. No clearing pass is needed.
// The result sits in an output register; while the receiver stalls the unit
// still takes the next base and computes it, then holds in the finish state
// until the output register is free.
module modular_exponentiation_unit #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [modexp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [modexp_pkg::CFG_W-1:0]     cfg_data_i,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [modexp_pkg::DATA_W-1:0]    s_axis_tdata,  // [31:0] base_value
  // output stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [modexp_pkg::DATA_W-1:0]    m_axis_tdata   // [31:0] power_result
);

  import modexp_pkg::*;

  `include "assert_macros.svh"

  localparam int W     = OPERAND_WIDTH;
  localparam int EW    = W + 2;            // headroom for 2r and r + b
  localparam int CNT_W = $clog2(W);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(W - 1);
  localparam logic [W-1:0]     ONE      = W'(1);

  // Configuration registers
  logic [CFG_W-1:0] exp_q, mod_q;

  // Control
  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             m_valid_q, m_valid_d;

  // Datapath
  logic [W-1:0]      a_q, a_d;      // serial multiplier operand, MSB first
  logic [W-1:0]      r_q, r_d;      // partial residue
  logic [W-1:0]      x_q, x_d;      // running power of the base
  logic [W-1:0]      acc_q, acc_d;  // running product
  logic [W-1:0]      e_q, e_d;      // exponent, shifted right per bit
  logic [DATA_W-1:0] m_data_q, m_data_d;

  logic [W:0]    modx;
  logic [EW-1:0] mod_e, dbl, t1, t2, t3;
  logic [W-1:0]  addend, step;
  logic          last;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // zero modulus means 2^W
  assign modx = (mod_q[W-1:0] == '0) ? {1'b1, {W{1'b0}}} : {1'b0, mod_q[W-1:0]};

  // One step of the interleaved multiplier: r = 2r + bit*addend (mod m).
  // Both intermediate values stay below 2m, so one trial subtract each.
  assign addend = (state_q == ST_REDUCE) ? ONE : x_q;
  assign mod_e  = {1'b0, modx};
  assign dbl    = {1'b0, r_q, 1'b0};
  assign t1     = (dbl >= mod_e) ? dbl - mod_e : dbl;
  assign t2     = t1 + (a_q[W-1] ? {2'b00, addend} : '0);
  assign t3     = (t2 >= mod_e) ? t2 - mod_e : t2;
  assign step   = t3[W-1:0];
  assign last   = (cnt_q == LAST_CNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= '0;
      mod_q <= CFG_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_EXPONENT: exp_q <= cfg_data_i;
        CFG_MODULUS:  mod_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    r_q      <= r_d;
    x_q      <= x_d;
    acc_q    <= acc_d;
    e_q      <= e_d;
    m_data_q <= m_data_d;
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    m_valid_d = m_valid_q;
    a_d       = a_q;
    r_d       = r_q;
    x_d       = x_q;
    acc_d     = acc_q;
    e_d       = e_q;
    m_data_d  = m_data_q;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          a_d   = s_axis_tdata[W-1:0];
          e_d   = exp_q[W-1:0];
          r_d   = '0;
          cnt_d = '0;
          if (exp_q[W-1:0] == '0) begin
            acc_d   = ONE;
            state_d = ST_FINISH;
          end else begin
            state_d = ST_REDUCE;
          end
        end
      end

      ST_REDUCE, ST_MUL, ST_SQR: begin
        r_d   = step;
        a_d   = a_q << 1;
        cnt_d = cnt_q + CNT_W'(1);
        if (last) begin
          r_d   = '0;
          cnt_d = '0;
          case (state_q)
            ST_REDUCE: begin
              // base mod m is ready, product starts at 1
              x_d   = step;
              acc_d = ONE;
              if (e_q[0]) begin
                a_d     = ONE;
                state_d = ST_MUL;
              end else begin
                a_d     = step;
                state_d = ST_SQR;
              end
            end
            ST_MUL: begin
              acc_d = step;
              if (e_q[W-1:1] == '0) begin
                state_d = ST_FINISH;  // no set bits left, skip the square
              end else begin
                a_d     = x_q;
                state_d = ST_SQR;
              end
            end
            default: begin
              // square done, move to next exponent bit
              x_d = step;
              e_d = e_q >> 1;
              if (e_q[1]) begin
                a_d     = acc_q;
                state_d = ST_MUL;
              end else begin
                a_d     = step;
                state_d = ST_SQR;
              end
            end
          endcase
        end
      end

      ST_FINISH: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = DATA_W'(acc_q);
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Residue stays reduced while the multiplier runs
  `ASSERT_PROP(a_res_bound, clk_i, rst_ni,
    (state_q == ST_REDUCE || state_q == ST_MUL || state_q == ST_SQR) |-> ({1'b0, r_q} < modx))
  // Power of the base stays reduced during multiply and square
  `ASSERT_PROP(a_pow_bound, clk_i, rst_ni,
    (state_q == ST_MUL || state_q == ST_SQR) |-> ({1'b0, x_q} < modx))
  // Exponent loop only runs with set bits remaining
  `ASSERT_NEVER(a_exp_live, clk_i, rst_ni,
    (state_q == ST_MUL || state_q == ST_SQR) && (e_q == '0))
  // A fresh result appears only out of the finish state
  `ASSERT_PROP(a_out_src, clk_i, rst_ni,
    $rose(m_valid_q) |-> $past(state_q == ST_FINISH))

endmodule
